>>> src/tmr_pkg.sv
// Shared types and constants for the three-counter interval timer.
// No dependencies.
package tmr_pkg;

  typedef enum logic [2:0] {
    CMD_CTRL  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_GATE  = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  localparam logic [1:0] ACC_LOW  = 2'd1;
  localparam logic [1:0] ACC_HIGH = 2'd2;
  localparam logic [1:0] ACC_BOTH = 2'd3;

  localparam logic [1:0]  SEL_READBACK = 2'd3;
  localparam logic [15:0] CNT_ALL      = 16'hFFFF;
  localparam logic [15:0] CNT_EVEN     = 16'hFFFE;
  localparam logic [15:0] CNT_CH1_INIT = 16'd18;
  localparam logic [7:0]  BYTE_IDLE    = 8'hFF;

  typedef struct packed {
    logic       step;
    logic [2:0] cmd;
    logic [1:0] sel;
    logic [7:0] data;
    logic       gate;
  } ctr_req_t;

  typedef struct packed {
    logic       lvl;
    logic       evt;
    logic [7:0] rd;
  } ctr_rsp_t;

  function automatic logic bad_mode(input logic [2:0] m);
    bad_mode = (m == 3'd1) || (m == 3'd4) || (m == 3'd5);
  endfunction

endpackage

>>> src/tmr_counter.sv
// One timer counter: control, data access, gate and tick handling.
// Depends on tmr_pkg.
module tmr_counter import tmr_pkg::*; #(
  parameter logic [1:0] CH = 2'd0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ctr_req_t req,
  output ctr_rsp_t rsp
);

  logic [15:0] cc_r, cc_nxt, rl_r, rl_nxt, hc_r, hc_nxt;
  logic [7:0]  hs_r, hs_nxt;
  logic [2:0]  md_r, md_nxt;
  logic [1:0]  am_r, am_nxt;
  logic bcd_r, bcd_nxt, g_r, g_nxt, lvl_r, lvl_nxt, wln_r, wln_nxt, rln_r, rln_nxt;
  logic ai_r, ai_nxt, lp_r, lp_nxt, ch_r, ch_nxt, sh_r, sh_nxt;
  logic       ntf, done, fin;
  logic [7:0] rd;
  logic [15:0] pv;
  logic [2:0]  m;

  always_comb begin
    cc_nxt = cc_r; rl_nxt = rl_r; hc_nxt = hc_r; hs_nxt = hs_r;
    md_nxt = md_r; am_nxt = am_r; bcd_nxt = bcd_r; g_nxt = g_r;
    lvl_nxt = lvl_r; wln_nxt = wln_r; rln_nxt = rln_r; ai_nxt = ai_r;
    lp_nxt = lp_r; ch_nxt = ch_r; sh_nxt = sh_r;
    ntf = 1'b0; done = 1'b0; fin = 1'b0; rd = BYTE_IDLE; pv = cc_r;
    m = req.data[3:1];
    case (req.cmd)
      CMD_CTRL: begin
        if (req.data[7:6] == SEL_READBACK) begin
          if (req.data[1 + CH]) begin
            if (!req.data[4] && !sh_r) begin
              hs_nxt = {lvl_r, 1'b0, ch_r ? 2'b00 : am_r, md_r, bcd_r};
              sh_nxt = 1'b1;
            end
            if (!req.data[5] && !ch_r) begin
              hc_nxt = cc_r; ch_nxt = 1'b1; rln_nxt = 1'b1;
            end
          end
        end else if (req.data[7:6] == CH) begin
          if (req.data[5:4] == 2'b00) begin
            if (!ch_r) begin
              hc_nxt = cc_r; ch_nxt = 1'b1; rln_nxt = 1'b1;
            end
          end else if (!bad_mode(m)) begin
            am_nxt = req.data[5:4];
            bcd_nxt = req.data[0];
            md_nxt = m;
            lvl_nxt = (m != 3'd0);
            ntf = (lvl_nxt != lvl_r);
            ai_nxt = 1'b1; wln_nxt = 1'b1; rln_nxt = 1'b1; lp_nxt = 1'b0;
          end
        end
      end
      CMD_WRITE: begin
        if (req.sel == CH) begin
          case (am_r)
            ACC_LOW: begin
              rl_nxt = {rl_r[15:8], req.data}; done = 1'b1;
            end
            ACC_HIGH: begin
              rl_nxt = {req.data, rl_r[7:0]}; done = 1'b1;
            end
            ACC_BOTH: begin
              if (wln_r) rl_nxt = {rl_r[15:8], req.data};
              else begin
                rl_nxt = {req.data, rl_r[7:0]}; done = 1'b1;
              end
              wln_nxt = !wln_r;
            end
            default: done = 1'b0;
          endcase
          if (done) begin
            if (md_r == 3'd0) begin
              lp_nxt = 1'b1;
              if (lvl_r) begin
                lvl_nxt = 1'b0; ntf = 1'b1;
              end
            end else if (ai_r) lp_nxt = 1'b1;
            ai_nxt = 1'b0;
          end
        end
      end
      CMD_READ: begin
        if (req.sel == CH) begin
          if (sh_r) begin
            sh_nxt = 1'b0; rd = hs_r;
          end else begin
            pv = ch_r ? hc_r : cc_r;
            case (am_r)
              ACC_LOW: begin
                rd = pv[7:0]; fin = 1'b1;
              end
              ACC_HIGH: begin
                rd = pv[15:8]; fin = 1'b1;
              end
              ACC_BOTH: begin
                if (rln_r) begin
                  rln_nxt = 1'b0; rd = pv[7:0];
                end else begin
                  rln_nxt = 1'b1; rd = pv[15:8]; fin = 1'b1;
                end
              end
              default: rd = BYTE_IDLE;
            endcase
            if (ch_r && fin) ch_nxt = 1'b0;
          end
        end
      end
      CMD_GATE: begin
        if (CH == 2'd2) begin
          g_nxt = req.gate;
          if ((md_r inside {3'd2, 3'd3, 3'd6, 3'd7}) && g_r && !req.gate && !lvl_r) begin
            lvl_nxt = 1'b1; ntf = 1'b1; ai_nxt = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (md_r inside {3'd0, 3'd2, 3'd3, 3'd6, 3'd7}) begin
          if (lp_r) begin
            cc_nxt = (md_r inside {3'd3, 3'd7}) ? (rl_r & CNT_EVEN) : rl_r;
            lp_nxt = 1'b0;
          end else if (g_r) begin
            if (md_r == 3'd0) begin
              if (cc_r == 16'd0) cc_nxt = CNT_ALL;
              else if (cc_r == 16'd1) begin
                cc_nxt = 16'd0;
                if (!lvl_r) begin
                  lvl_nxt = 1'b1; ntf = 1'b1;
                end
              end else cc_nxt = cc_r - 16'd1;
            end else if (md_r inside {3'd2, 3'd6}) begin
              if (cc_r == 16'd0) cc_nxt = CNT_ALL;
              else if (cc_r == 16'd1) begin
                cc_nxt = rl_r; lvl_nxt = 1'b1; ntf = 1'b1;
              end else if (cc_r == 16'd2) begin
                cc_nxt = 16'd1; lvl_nxt = 1'b0; ntf = 1'b1;
              end else cc_nxt = cc_r - 16'd1;
            end else begin
              if (cc_r > 16'd4) cc_nxt = cc_r - 16'd2;
              else if (cc_r == 16'd4) cc_nxt = 16'd2;
              else if (cc_r == 16'd3 || cc_r == 16'd2) begin
                cc_nxt = rl_r & CNT_EVEN; lvl_nxt = !lvl_r; ntf = 1'b1;
              end else cc_nxt = CNT_EVEN;
            end
          end
        end
      end
      default: ntf = 1'b0;
    endcase
  end

  assign rsp.lvl = lvl_nxt;
  assign rsp.evt = ntf && lvl_nxt;
  assign rsp.rd  = rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= (CH == 2'd1) ? CNT_CH1_INIT : 16'd0;
      rl_r <= (CH == 2'd1) ? CNT_CH1_INIT : 16'd0;
      hc_r <= 16'd0; hs_r <= 8'd0; md_r <= 3'd2; am_r <= ACC_LOW;
      bcd_r <= 1'b0; g_r <= (CH != 2'd2); lvl_r <= 1'b0; wln_r <= 1'b0;
      rln_r <= 1'b0; ai_r <= 1'b0; lp_r <= 1'b0; ch_r <= 1'b0; sh_r <= 1'b0;
    end else if (req.step) begin
      cc_r <= cc_nxt; rl_r <= rl_nxt; hc_r <= hc_nxt; hs_r <= hs_nxt;
      md_r <= md_nxt; am_r <= am_nxt; bcd_r <= bcd_nxt; g_r <= g_nxt;
      lvl_r <= lvl_nxt; wln_r <= wln_nxt; rln_r <= rln_nxt; ai_r <= ai_nxt;
      lp_r <= lp_nxt; ch_r <= ch_nxt; sh_r <= sh_nxt;
    end
  end

endmodule

>>> src/three_channel_interval_timer_top.sv
// Top level of the three-counter interval timer: handshake, result register.
// Depends on tmr_pkg and tmr_counter.
// Each item (bus access, gate change or tick) is accepted when not stalled and
// its result appears in the output register on the next edge; one item per
// cycle is sustained while the result side keeps up.
module three_channel_interval_timer_top import tmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [1:0] in_counter_select,
  input  logic [7:0] in_data_byte,
  input  logic       in_gate_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_zero,
  output logic       out_one,
  output logic       out_two,
  output logic       out_refresh_toggle,
  output logic       out_mode_error
);

  ctr_req_t   req;
  ctr_rsp_t   rsp [3];
  logic       acc, err, ov_r, rf_r, rf_nxt;
  logic [7:0] rd;

  assign in_stall = ov_r && out_stall;
  assign acc = in_valid && !in_stall;

  assign req.step = acc;
  assign req.cmd  = in_command;
  assign req.sel  = in_counter_select;
  assign req.data = in_data_byte;
  assign req.gate = in_gate_level;

  tmr_counter #(.CH(2'd0)) u_c0 (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp[0]));
  tmr_counter #(.CH(2'd1)) u_c1 (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp[1]));
  tmr_counter #(.CH(2'd2)) u_c2 (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp[2]));

  always_comb begin
    rd = BYTE_IDLE;
    if (in_command == CMD_READ) begin
      case (in_counter_select)
        2'd0: rd = rsp[0].rd;
        2'd1: rd = rsp[1].rd;
        2'd2: rd = rsp[2].rd;
        default: rd = BYTE_IDLE;
      endcase
    end
  end

  assign err = (in_command == CMD_CTRL) && (in_data_byte[7:6] != SEL_READBACK) &&
               (in_data_byte[5:4] != 2'b00) && bad_mode(in_data_byte[3:1]);
  assign rf_nxt = rf_r ^ rsp[1].evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      rf_r <= 1'b0;
    end else begin
      if (acc) begin
        ov_r <= 1'b1;
        rf_r <= rf_nxt;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_read_data      <= rd;
      out_zero           <= rsp[0].lvl;
      out_one            <= rsp[1].lvl;
      out_two            <= rsp[2].lvl;
      out_refresh_toggle <= rf_nxt;
      out_mode_error     <= err;
    end
  end

  assign out_valid = ov_r;

`ifndef SYNTHESIS
  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid) else $error("accepted item produced no result");
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with empty result register");
  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode_error) |-> (out_read_data == BYTE_IDLE))
    else $error("mode error with read data");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the three-counter interval timer.
// Depends on tmr_pkg and three_channel_interval_timer_top; a built-in timer
// predictor checks every result item in order under varied idle and stall.
`timescale 1ns / 100ps

module tb_top;
  import tmr_pkg::*;

  typedef struct packed {
    logic [2:0] cmd;
    logic [1:0] sel;
    logic [7:0] data;
    logic       gate;
  } timer_cmd_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       o0;
    logic       o1;
    logic       o2;
    logic       tog;
    logic       err;
  } timer_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [1:0] in_counter_select = '0;
  logic [7:0] in_data_byte = '0;
  logic in_gate_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic out_zero, out_one, out_two, out_refresh_toggle, out_mode_error;

  three_channel_interval_timer_top u_dut (.*);

  always #2 clk = ~clk;

  // predictor state
  logic [15:0] cur_cnt [3];
  logic [15:0] reload [3];
  logic [15:0] latched_cnt [3];
  logic [7:0]  latched_sts [3];
  logic [2:0]  mode [3];
  logic [1:0]  acc [3];
  logic        bcd [3], gate [3], lvl [3], wr_lo [3], rd_lo [3];
  logic        await_init [3], pend [3], cnt_held [3], sts_held [3];
  logic        refresh;

  timer_cmd_t  pending_cmds [$];
  timer_rsp_t  expected_rsps [$];
  int          sent_idle_pct = 0, stall_pct = 0;
  int          mismatches = 0, checked = 0;
  longint      cycles = 0;

  function automatic void model_reset();
    for (int i = 0; i < 3; i++) begin
      cur_cnt[i] = 0; reload[i] = 0; latched_cnt[i] = 0; latched_sts[i] = 0;
      mode[i] = 3'd2; acc[i] = ACC_LOW; bcd[i] = 0; lvl[i] = 0;
      wr_lo[i] = 0; rd_lo[i] = 0; await_init[i] = 0; pend[i] = 0;
      cnt_held[i] = 0; sts_held[i] = 0;
    end
    gate[0] = 1; gate[1] = 1; gate[2] = 0;
    cur_cnt[1] = CNT_CH1_INIT; reload[1] = CNT_CH1_INIT;
    refresh = 0;
  endfunction

  function automatic void drive_level(int c, logic v, bit always_note);
    logic old;
    old = lvl[c];
    lvl[c] = v;
    if ((always_note || old != v) && c == 1 && lvl[1]) refresh = ~refresh;
  endfunction

  function automatic void hold_count(int c);
    if (!cnt_held[c]) begin
      latched_cnt[c] = cur_cnt[c]; cnt_held[c] = 1; rd_lo[c] = 1;
    end
  endfunction

  function automatic void tick_counter(int c);
    logic [2:0] m;
    logic [15:0] n;
    m = mode[c];
    n = cur_cnt[c];
    if (!(m == 0 || m == 2 || m == 3 || m == 6 || m == 7)) return;
    if (pend[c]) begin
      cur_cnt[c] = (m == 3 || m == 7) ? (reload[c] & CNT_EVEN) : reload[c];
      pend[c] = 0;
      return;
    end
    if (!gate[c]) return;
    if (m == 0) begin
      if (n == 0) cur_cnt[c] = CNT_ALL;
      else if (n == 1) begin
        cur_cnt[c] = 0;
        if (!lvl[c]) drive_level(c, 1, 1);
      end else cur_cnt[c] = n - 1;
    end else if (m == 2 || m == 6) begin
      if (n == 0) cur_cnt[c] = CNT_ALL;
      else if (n == 1) begin cur_cnt[c] = reload[c]; drive_level(c, 1, 1); end
      else if (n == 2) begin cur_cnt[c] = 1; drive_level(c, 0, 1); end
      else cur_cnt[c] = n - 1;
    end else begin
      if (n > 4) cur_cnt[c] = n - 2;
      else if (n == 4) cur_cnt[c] = 2;
      else if (n >= 2) begin
        cur_cnt[c] = reload[c] & CNT_EVEN;
        drive_level(c, ~lvl[c], 1);
      end else cur_cnt[c] = CNT_EVEN;
    end
  endfunction

  function automatic logic ctrl_word(logic [7:0] d);
    int c;
    logic [7:0] s;
    logic [2:0] m;
    if (d[7:6] == 2'b11) begin
      if (!d[4])
        for (int i = 0; i < 3; i++)
          if (d[i+1] && !sts_held[i]) begin
            s = {lvl[i], 1'b0, cnt_held[i] ? 2'b00 : acc[i], mode[i], bcd[i]};
            latched_sts[i] = s; sts_held[i] = 1;
          end
      if (!d[5])
        for (int i = 0; i < 3; i++) if (d[i+1]) hold_count(i);
      return 0;
    end
    c = d[7:6];
    if (d[5:4] == 0) begin hold_count(c); return 0; end
    m = d[3:1];
    if (m == 1 || m == 4 || m == 5) return 1;
    acc[c] = d[5:4]; bcd[c] = d[0]; mode[c] = m;
    drive_level(c, m != 0, 0);
    await_init[c] = 1; wr_lo[c] = 1; rd_lo[c] = 1; pend[c] = 0;
    return 0;
  endfunction

  function automatic void count_write(int c, logic [7:0] d);
    bit done;
    done = 0;
    if (acc[c] == ACC_LOW) begin reload[c][7:0] = d; done = 1; end
    else if (acc[c] == ACC_HIGH) begin reload[c][15:8] = d; done = 1; end
    else if (acc[c] == ACC_BOTH) begin
      if (wr_lo[c]) reload[c][7:0] = d;
      else begin reload[c][15:8] = d; done = 1; end
      wr_lo[c] = ~wr_lo[c];
    end
    if (!done) return;
    if (mode[c] == 0) begin
      pend[c] = 1;
      if (lvl[c]) drive_level(c, 0, 1);
    end else if (await_init[c]) pend[c] = 1;
    await_init[c] = 0;
  endfunction

  function automatic logic [7:0] pick_byte(int c, logic [15:0] v, output bit fin);
    fin = 1;
    if (acc[c] == ACC_LOW) return v[7:0];
    if (acc[c] == ACC_HIGH) return v[15:8];
    if (acc[c] == ACC_BOTH) begin
      if (rd_lo[c]) begin rd_lo[c] = 0; fin = 0; return v[7:0]; end
      rd_lo[c] = 1;
      return v[15:8];
    end
    fin = 0;
    return BYTE_IDLE;
  endfunction

  function automatic logic [7:0] count_read(int c);
    bit fin;
    logic [7:0] r;
    if (sts_held[c]) begin sts_held[c] = 0; return latched_sts[c]; end
    if (cnt_held[c]) begin
      r = pick_byte(c, latched_cnt[c], fin);
      if (fin) cnt_held[c] = 0;
      return r;
    end
    return pick_byte(c, cur_cnt[c], fin);
  endfunction

  function automatic timer_rsp_t timer_step(timer_cmd_t t);
    timer_rsp_t r;
    logic old;
    r.rd = BYTE_IDLE; r.err = 0;
    case (t.cmd)
      CMD_CTRL: r.err = ctrl_word(t.data);
      CMD_WRITE: if (t.sel != SEL_READBACK) count_write(t.sel, t.data);
      CMD_READ: if (t.sel != SEL_READBACK) r.rd = count_read(t.sel);
      CMD_GATE: begin
        old = gate[2];
        gate[2] = t.gate;
        if ((mode[2] inside {3'd2, 3'd3, 3'd6, 3'd7}) && old && !t.gate && !lvl[2]) begin
          drive_level(2, 1, 1);
          await_init[2] = 1;
        end
      end
      CMD_TICK: for (int i = 0; i < 3; i++) tick_counter(i);
      default: ;
    endcase
    r.o0 = lvl[0]; r.o1 = lvl[1]; r.o2 = lvl[2]; r.tog = refresh;
    return r;
  endfunction

  function automatic timer_cmd_t mk(logic [2:0] c, logic [1:0] s, logic [7:0] d, logic g);
    timer_cmd_t t;
    t.cmd = c; t.sel = s; t.data = d; t.gate = g;
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sent_idle_pct) begin
          timer_cmd_t t;
          t = pending_cmds.pop_front();
          expected_rsps.push_back(timer_step(t));
          in_valid <= 1'b1;
          in_command <= t.cmd; in_counter_select <= t.sel;
          in_data_byte <= t.data; in_gate_level <= t.gate;
        end else in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      timer_rsp_t got, exp_r;
      got = {out_read_data, out_zero, out_one, out_two, out_refresh_toggle, out_mode_error};
      checked++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch item %0d: exp rd=%h o=%b%b%b t=%b e=%b got rd=%h o=%b%b%b t=%b e=%b",
                     checked, exp_r.rd, exp_r.o0, exp_r.o1, exp_r.o2, exp_r.tog, exp_r.err,
                     got.rd, got.o0, got.o1, got.o2, got.tog, got.err);
        end
      end
    end
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic timer_cmd_t rand_cmd();
    int k;
    logic [7:0] d;
    k = $urandom_range(99);
    d = 8'($urandom);
    if (k < 12) begin
      if ($urandom_range(3) == 0) d = {2'b11, d[5:0]};
      else d[3:1] = 3'($urandom_range(1) ? 0 : 2 + $urandom_range(1)) | (d[3] ? 3'd4 : 3'd0);
      return mk(CMD_CTRL, 2'($urandom_range(3)), d, 1'($urandom));
    end
    if (k < 30)
      return mk(CMD_WRITE, 2'($urandom_range(3)),
                ($urandom_range(3) == 0) ? d : {5'd0, d[2:0]}, 1'($urandom));
    if (k < 45) return mk(CMD_READ, 2'($urandom_range(3)), d, 1'($urandom));
    if (k < 52) return mk(CMD_GATE, 2'($urandom_range(3)), d, 1'($urandom));
    if (k < 98) return mk(CMD_TICK, 2'($urandom_range(3)), d, 1'($urandom));
    return mk(3'(5 + $urandom_range(2)), 2'($urandom_range(3)), d, 1'($urandom));
  endfunction

  task automatic run_phase(int idle, int stl, int n);
    sent_idle_pct = idle; stall_pct = stl;
    for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd());
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: modes 0, 2, 3 and 7 plus an illegal mode, access kinds, latches, read-back, odd square counts
    pending_cmds.push_back(mk(CMD_READ, 2'd1, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h02, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h38, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h30, 0));
    pending_cmds.push_back(mk(CMD_WRITE, 0, 8'h03, 0));
    pending_cmds.push_back(mk(CMD_WRITE, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'hB7, 0));
    pending_cmds.push_back(mk(CMD_WRITE, 2, 8'h03, 0));
    pending_cmds.push_back(mk(CMD_GATE, 0, 8'h00, 1));
    for (int i = 0; i < 6; i++) pending_cmds.push_back(mk(CMD_TICK, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_GATE, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h74, 0));
    pending_cmds.push_back(mk(CMD_WRITE, 1, 8'hFF, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'hCE, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_READ, 3, 8'h00, 0));
    pending_cmds.push_back(mk(CMD_WRITE, 3, 8'h55, 0));
    pending_cmds.push_back(mk(3'd7, 3, 8'hFF, 1));
    pending_cmds.push_back(mk(CMD_CTRL, 0, 8'h5E, 0));
    run_phase(0, 0, 0);
    run_phase(0, 0, 160);
    run_phase(51, 0, 160);
    run_phase(0, 51, 160);
    run_phase(27, 27, 170);
    sent_idle_pct = 100;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d result items over directed modes and four idle/stall phases",
             checked);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
